### hdl/pcrc_pkg.sv
// shared types and constants for the programmable serial crc block
package pcrc_pkg;

    localparam int MAX_DEGREE_DEF = 32;
    localparam int POLY_W         = 32;
    localparam int LEN_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int BYTE_W         = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_POLY = 2'd2;

    localparam logic [1:0] KIND_BIT   = 2'd0;
    localparam logic [1:0] KIND_PASS  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;
    localparam logic [1:0] KIND_SHORT = 2'd3;

    typedef enum logic [1:0] {
        CRC_HOLD  = 2'd0,
        CRC_STEP  = 2'd1,
        CRC_CLEAR = 2'd2
    } t_crc_op;

    typedef enum logic [1:0] {
        AUG_HOLD  = 2'd0,
        AUG_STEP  = 2'd1,
        AUG_LOAD  = 2'd2,
        AUG_CLEAR = 2'd3
    } t_aug_op;

    // shared controls broadcast along the row of cells
    typedef struct packed {
        t_crc_op crc_op;
        t_aug_op aug_op;
        logic    crc_fb;
        logic    aug_fb;
    } t_cell_ctl;

endpackage

### hdl/pcrc_cell.sv
// one bit slice of the division register and of the augmented remainder register
module pcrc_cell
    import pcrc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_active,
    input  logic      i_poly_bit,
    input  logic      i_crc_prev,
    input  logic      i_aug_prev,
    output logic      o_crc,
    output logic      o_crc_nxt,
    output logic      o_aug
);

    logic r_crc;
    logic r_aug;
    logic n_crc;
    logic n_aug;
    logic w_aug_nxt;

    // slices at or above the degree stay zero
    assign o_crc_nxt = i_active & (i_crc_prev ^ (i_ctl.crc_fb & i_poly_bit));
    assign w_aug_nxt = i_active & (i_aug_prev ^ (i_ctl.aug_fb & i_poly_bit));

    always_comb begin
        case (i_ctl.crc_op)
            CRC_STEP:  n_crc = o_crc_nxt;
            CRC_CLEAR: n_crc = 1'b0;
            default:   n_crc = r_crc;
        endcase
        case (i_ctl.aug_op)
            AUG_STEP:  n_aug = w_aug_nxt;
            AUG_LOAD:  n_aug = o_crc_nxt;
            AUG_CLEAR: n_aug = 1'b0;
            default:   n_aug = r_aug;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 1'b0;
            r_aug <= 1'b0;
        end else begin
            r_crc <= n_crc;
            r_aug <= n_aug;
        end
    end

    assign o_crc = r_crc;
    assign o_aug = r_aug;

endmodule

### hdl/programmable_crc_generate_check_top.sv
// top level: programmable serial crc generator and checker on a row of bit cells
// an input transfer's result is written to the output register in the next cycle
// throughput: one bit per cycle in run state with the output free; in generate mode the last bit
// adds degree bits of remainder, after degree division steps if the generator changed mid-message
// check mode gives one verdict on the last bit, taking one bit per cycle while the output is free
// reset (synchronous, active low) clears remainder, bit count, out valid, mode 0, length 9, poly 7
module programmable_crc_generate_check_top
    import pcrc_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POLY_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [0] data_bit
    input  logic                 s_axis_tlast,   // last_bit
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata,   // [0] out_bit
    output logic [1:0]           m_axis_tuser,   // [1:0] result_kind
    output logic                 m_axis_tlast    // is_last
);

    localparam int DEG_W = $clog2(MAX_DEGREE + 1);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [DEG_W-1:0]  r_cnt, n_cnt;
    logic [LEN_W-1:0]  r_bits, n_bits;
    logic              r_dirty, n_dirty;
    logic              r_mode;
    logic [LEN_W-1:0]  r_gen_len;
    logic [POLY_W-1:0] r_gen_poly;
    logic              r_out_valid, n_out_valid;
    logic              r_out_bit, n_out_bit;
    logic [1:0]        r_out_kind, n_out_kind;
    logic              r_out_last, n_out_last;

    logic [LEN_W-1:0]      w_len_c;
    logic [LEN_W-1:0]      w_deg6;
    logic [DEG_W-1:0]      w_deg;
    logic [DEG_W-1:0]      w_deg_m1;
    logic [LEN_W-1:0]      w_bits_nxt;
    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_bit;
    logic                  w_crc_in0;
    logic                  w_crc_top;
    logic                  w_aug_top;
    logic [1:0]            w_verdict;
    t_cell_ctl             w_ctl;
    logic [MAX_DEGREE-1:0] w_active;
    logic [MAX_DEGREE-1:0] w_is_top;
    logic [MAX_DEGREE-1:0] w_poly;
    logic [MAX_DEGREE-1:0] w_crc;
    logic [MAX_DEGREE-1:0] w_crc_nxt;
    logic [MAX_DEGREE-1:0] w_aug;

    // effective degree: length clamped to 2..33, degree capped at the row size
    always_comb begin
        if (r_gen_len < LEN_W'(2)) begin
            w_len_c = LEN_W'(2);
        end else if (r_gen_len > LEN_W'(33)) begin
            w_len_c = LEN_W'(33);
        end else begin
            w_len_c = r_gen_len;
        end
        w_deg6 = w_len_c - LEN_W'(1);
        if ({1'b0, w_deg6} > 7'(MAX_DEGREE)) begin
            w_deg = DEG_W'(MAX_DEGREE);
        end else begin
            w_deg = DEG_W'(w_deg6);
        end
        w_deg_m1 = w_deg - DEG_W'(1);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_DEGREE; g++) begin : g_cell
            logic w_crc_prev;
            logic w_aug_prev;

            assign w_active[g] = (DEG_W'(g) < w_deg);
            assign w_is_top[g] = (DEG_W'(g) == w_deg_m1);

            if (g < POLY_W) begin : g_poly
                assign w_poly[g] = r_gen_poly[g];
            end else begin : g_nopoly
                assign w_poly[g] = 1'b0;
            end

            if (g == 0) begin : g_first
                assign w_crc_prev = w_crc_in0;
                assign w_aug_prev = 1'b0;
            end else begin : g_rest
                assign w_crc_prev = w_crc[g-1];
                assign w_aug_prev = w_aug[g-1];
            end

            pcrc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_active   (w_active[g]),
                .i_poly_bit (w_poly[g]),
                .i_crc_prev (w_crc_prev),
                .i_aug_prev (w_aug_prev),
                .o_crc      (w_crc[g]),
                .o_crc_nxt  (w_crc_nxt[g]),
                .o_aug      (w_aug[g])
            );
        end
    endgenerate

    assign w_crc_top = |(w_crc & w_is_top);
    assign w_aug_top = |(w_aug & w_is_top);

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_RUN) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_bit         = s_axis_tdata[0];
    assign w_bits_nxt    = (r_bits == {LEN_W{1'b1}}) ? r_bits : r_bits + LEN_W'(1);

    // short when fewer bits than degree plus one
    always_comb begin
        if ({1'b0, w_bits_nxt} <= 7'(w_deg)) begin
            w_verdict = KIND_SHORT;
        end else if (|w_crc_nxt) begin
            w_verdict = KIND_FAIL;
        end else begin
            w_verdict = KIND_PASS;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bits      = r_bits;
        n_dirty     = r_dirty;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;
        n_out_kind  = r_out_kind;
        n_out_last  = r_out_last;
        w_crc_in0   = 1'b0;
        w_ctl.crc_op = CRC_HOLD;
        w_ctl.aug_op = AUG_HOLD;
        w_ctl.crc_fb = w_crc_top;
        w_ctl.aug_fb = 1'b0;

        // a generator change mid-message invalidates the augmented register
        if (i_cfg_we && (i_cfg_idx == REG_GEN_LEN || i_cfg_idx == REG_GEN_POLY)
                && (r_bits != '0 || w_accept)) begin
            n_dirty = 1'b1;
        end

        case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    w_crc_in0    = w_bit;
                    w_ctl.crc_op = CRC_STEP;
                    w_ctl.aug_op = AUG_STEP;
                    w_ctl.aug_fb = w_aug_top ^ w_bit;
                    n_bits       = w_bits_nxt;
                    if (!r_mode) begin
                        n_out_valid = 1'b1;
                        n_out_bit   = w_bit;
                        n_out_kind  = KIND_BIT;
                        n_out_last  = 1'b0;
                    end else if (s_axis_tlast) begin
                        n_out_valid = 1'b1;
                        n_out_bit   = 1'b0;
                        n_out_kind  = w_verdict;
                        n_out_last  = 1'b1;
                    end else begin
                        n_out_valid = 1'b0;
                    end
                    if (s_axis_tlast) begin
                        n_bits  = '0;
                        n_dirty = 1'b0;
                        n_cnt   = '0;
                        if (r_mode) begin
                            w_ctl.crc_op = CRC_CLEAR;
                            w_ctl.aug_op = AUG_CLEAR;
                        end else if (r_dirty) begin
                            w_ctl.aug_op = AUG_HOLD;
                            n_state      = ST_FLUSH;
                        end else begin
                            w_ctl.crc_op = CRC_CLEAR;
                            n_state      = ST_DRAIN;
                        end
                    end
                end else if (w_out_free) begin
                    n_out_valid = 1'b0;
                end
            end
            ST_FLUSH: begin
                // zero-padding division steps, then hand the remainder to the shift-out row
                w_ctl.crc_op = CRC_STEP;
                if (w_out_free) begin
                    n_out_valid = 1'b0;
                end
                n_cnt = r_cnt + DEG_W'(1);
                if (r_cnt == w_deg_m1) begin
                    w_ctl.crc_op = CRC_CLEAR;
                    w_ctl.aug_op = AUG_LOAD;
                    n_cnt        = '0;
                    n_state      = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_bit    = w_aug_top;
                    n_out_kind   = KIND_BIT;
                    n_out_last   = (r_cnt == w_deg_m1);
                    w_ctl.aug_op = AUG_STEP;
                    n_cnt        = r_cnt + DEG_W'(1);
                    if (r_cnt == w_deg_m1) begin
                        n_cnt   = '0;
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_bits      <= '0;
            r_dirty     <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_gen_len   <= LEN_W'(9);
            r_gen_poly  <= POLY_W'(7);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bits      <= n_bits;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:     r_mode     <= i_cfg_data[0];
                    REG_GEN_LEN:  r_gen_len  <= i_cfg_data[LEN_W-1:0];
                    REG_GEN_POLY: r_gen_poly <= i_cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit  <= n_out_bit;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(BYTE_W-1){1'b0}}, r_out_bit};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
